/* hw/rtl/atr_pkg.sv */
// Shared constants and controller/datapath interface types for the
// average true range unit. No dependencies.
package atr_pkg;

  localparam int MAX_WINDOW    = 64;
  localparam int PRICE_BITS    = 32;
  localparam int FRACTION_BITS = 8;

  // Fixed field widths.
  localparam int WIN_W   = 7;
  localparam int VALUE_W = 40;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(14);

  // Ring addressing assumes a power-of-two depth so the pointer wraps naturally.
  localparam int RING_AW = $clog2(MAX_WINDOW);
  localparam int HELD_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = PRICE_BITS + RING_AW;

  // Radix-4 restoring divider: two quotient bits per cycle.
  localparam int DIV_W     = SUM_W + FRACTION_BITS;
  localparam int DIV_STEPS = (DIV_W + 1) / 2;
  localparam int DIV_PAD_W = 2 * DIV_STEPS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;      // latch the input bar
    logic diff;      // form the three absolute differences, read the oldest range
    logic max;       // pick the true range, retire the oldest range from the sum
    logic acc;       // store the true range, add it to the sum
    logic div_init;  // load the divider with the scaled sum
    logic div_step;  // one radix-4 divider step
    logic out_load;  // move the result into the output register
  } atr_cmd_t;

  typedef struct packed {
    logic have_prev;  // a previous close exists in the current series
    logic full_next;  // the window is full once the current range is stored
  } atr_sts_t;

endpackage

/* hw/rtl/atr_ctrl.sv */
// Sequencing controller for the average true range unit.
// Depends on atr_pkg; drives the datapath through atr_cmd_t.
module atr_ctrl
  import atr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_start,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  atr_sts_t sts,
  output atr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_MAX, S_ACC, S_DINIT, S_DIV, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               in_fire;
  logic               out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          // The first bar of a series forms no true range.
          if (in_start || !sts.have_prev) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MAX;
      end
      S_MAX: begin
        cmd.max   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.full_next ? S_DINIT : S_OUT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/atr_dp.sv */
// Datapath of the average true range unit: range ring, running sum,
// serial divider and output register. Depends on atr_pkg.
module atr_dp
  import atr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  atr_cmd_t                cmd,
  output atr_sts_t                sts,
  input  logic                    cfg_wr_en,
  input  logic [WIN_W-1:0]        cfg_wr_data,
  input  logic [PRICE_BITS-1:0]   in_high,
  input  logic [PRICE_BITS-1:0]   in_low,
  input  logic [PRICE_BITS-1:0]   in_close,
  input  logic                    in_start,
  output logic [VALUE_W-1:0]      out_value,
  output logic                    out_flag
);

  logic [WIN_W-1:0]      win_r;
  logic [WIN_W-1:0]      n_eff;
  logic                  clear;

  logic [PRICE_BITS-1:0] hi_r, lo_r, cl_r, prev_close_r;
  logic                  have_prev_r;
  logic [PRICE_BITS-1:0] d1_r, d2_r, d3_r, tr_r, old_r;
  logic [PRICE_BITS-1:0] tr_nxt;
  logic [SUM_W-1:0]      sum_r;
  logic [RING_AW-1:0]    pos_r;
  logic [RING_AW-1:0]    oldest_addr;
  logic [HELD_W-1:0]     held_r;
  logic                  held_full;

  logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];

  logic [DIV_PAD_W-1:0]  div_sh_r, div_sh_nxt;
  logic [WIN_W-1:0]      rem_r, rem_nxt, rem_mid;
  logic [WIN_W:0]        rem_a, rem_b;
  logic                  q_hi, q_lo;
  logic                  res_valid_r;

  logic [VALUE_W-1:0]    out_value_r;
  logic                  out_flag_r;

  function automatic logic [PRICE_BITS-1:0] abs_diff(
    input logic [PRICE_BITS-1:0] a,
    input logic [PRICE_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // A window of zero acts as one; anything above the ring depth is clamped.
  always_comb begin
    if (win_r == '0) begin
      n_eff = WIN_W'(1);
    end else if (win_r > WIN_W'(MAX_WINDOW)) begin
      n_eff = WIN_W'(MAX_WINDOW);
    end else begin
      n_eff = win_r;
    end
  end

  assign clear       = cfg_wr_en || (cmd.load && in_start);
  assign held_full   = (WIN_W'(held_r) >= n_eff);
  assign oldest_addr = pos_r - n_eff[RING_AW-1:0];

  assign sts.have_prev = have_prev_r;
  assign sts.full_next = (WIN_W'(held_r) + WIN_W'(1) >= n_eff);

  always_comb begin
    tr_nxt = d1_r;
    if (d2_r > tr_nxt) tr_nxt = d2_r;
    if (d3_r > tr_nxt) tr_nxt = d3_r;
  end

  // Two restoring steps; the remainder always stays below the window length.
  always_comb begin
    rem_a      = {rem_r, div_sh_r[DIV_PAD_W-1]};
    q_hi       = (rem_a >= {1'b0, n_eff});
    rem_mid    = q_hi ? WIN_W'(rem_a - {1'b0, n_eff}) : rem_a[WIN_W-1:0];
    rem_b      = {rem_mid, div_sh_r[DIV_PAD_W-2]};
    q_lo       = (rem_b >= {1'b0, n_eff});
    rem_nxt    = q_lo ? WIN_W'(rem_b - {1'b0, n_eff}) : rem_b[WIN_W-1:0];
    div_sh_nxt = {div_sh_r[DIV_PAD_W-3:0], q_hi, q_lo};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_RESET;
      have_prev_r <= 1'b0;
      sum_r       <= '0;
      pos_r       <= '0;
      held_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (clear) begin
        have_prev_r <= 1'b0;
        sum_r       <= '0;
        pos_r       <= '0;
        held_r      <= '0;
      end else begin
        if (cmd.max && held_full) begin
          sum_r <= sum_r - SUM_W'(old_r);
        end
        if (cmd.acc) begin
          sum_r <= sum_r + SUM_W'(tr_r);
          pos_r <= pos_r + RING_AW'(1);
          if (!held_full) begin
            held_r <= held_r + HELD_W'(1);
          end
        end
        if (cmd.out_load) begin
          have_prev_r <= 1'b1;
        end
      end
      if (cmd.load) begin
        res_valid_r <= 1'b0;
      end else if (cmd.div_init) begin
        res_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_r <= in_high;
      lo_r <= in_low;
      cl_r <= in_close;
    end
    if (cmd.diff) begin
      d1_r <= abs_diff(hi_r, lo_r);
      d2_r <= abs_diff(hi_r, prev_close_r);
      d3_r <= abs_diff(lo_r, prev_close_r);
    end
    if (cmd.max) begin
      tr_r <= tr_nxt;
    end
    if (cmd.div_init) begin
      div_sh_r <= DIV_PAD_W'({sum_r, FRACTION_BITS'(0)});
      rem_r    <= '0;
    end else if (cmd.div_step) begin
      div_sh_r <= div_sh_nxt;
      rem_r    <= rem_nxt;
    end
    if (cmd.out_load) begin
      prev_close_r <= cl_r;
      out_value_r  <= res_valid_r ? div_sh_r[VALUE_W-1:0] : '0;
      out_flag_r   <= res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      old_r <= ring_mem[oldest_addr];
    end
    if (cmd.acc) begin
      ring_mem[pos_r] <= tr_r;
    end
  end

  assign out_value = out_value_r;
  assign out_flag  = out_flag_r;

endmodule

/* hw/rtl/average_true_range_unit.sv */
// Top level of the average true range unit: stream ports, controller and datapath.
// Depends on atr_pkg, atr_ctrl and atr_dp.

// Takes one price bar per transfer and returns exactly one result per bar, in
// order. A bar that starts a series (or the first bar after reset or after a
// window write) goes from its transfer straight to the output state, which
// loads its zero, invalid result into the output register. A bar whose true
// range does not yet fill the window first passes through the difference,
// maximum and accumulate states. Every other bar also passes through the
// radix-4 divider that divides the scaled running sum by the window. In each
// case the input is ready again only once the result has been loaded. While a
// result waits in the output register the next bar is already taken and worked
// on; it stalls just before its own result is loaded until the waiting result
// has been taken. Write cfg_wr_data only when no bar is in flight; every write
// also clears the series.
module average_true_range_unit
  import atr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [WIN_W-1:0]      cfg_wr_data,   // window_length
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,      // high_price, low_price, close_price
  input  logic                  in_tuser,      // start_series
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,     // atr_value
  output logic                  out_tuser      // atr_valid
);

  atr_cmd_t cmd;
  atr_sts_t sts;

  atr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_start   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  atr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_high     (in_tdata[PRICE_BITS-1:0]),
    .in_low      (in_tdata[2*PRICE_BITS-1:PRICE_BITS]),
    .in_close    (in_tdata[3*PRICE_BITS-1:2*PRICE_BITS]),
    .in_start    (in_tuser),
    .out_value   (out_tdata),
    .out_flag    (out_tuser)
  );

endmodule

/* hw/rtl/atr_checker.sv */
// Port-level checker for average_true_range_unit, attached by bind.
// Depends on atr_pkg.
module atr_checker
  import atr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An invalid average always reads as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero value on an invalid result");

  // The unit works on one bar at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second bar taken while one is in flight");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind average_true_range_unit atr_checker u_atr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/testbench.sv */
// Self-checking testbench for average_true_range_unit: streams price bars through
// the unit and compares every result with a behavioral model of the indicator.
// Depends on atr_pkg and the unit's RTL.
`timescale 1ns / 100ps

module testbench;
  import atr_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int DRAIN    = 40;   // longer than the time the unit takes for one bar

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               valid;
  } atr_result_t;

  // Tracks the indicator state and holds the results still owed by the unit.
  class atr_tracker;
    logic [WIN_W-1:0]      window_reg;
    logic [PRICE_BITS-1:0] last_close;
    bit                    have_close;
    logic [PRICE_BITS-1:0] ranges[MAX_WINDOW];
    logic [SUM_W-1:0]      range_total;
    int                    slot;
    int                    held;
    atr_result_t           expected_atr[$];
    int                    errors;

    function new();
      window_reg = WIN_RESET;
      errors = 0;
      restart_series();
    endfunction

    function void restart_series();
      have_close = 0;
      last_close = '0;
      range_total = '0;
      slot = 0;
      held = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] v);
      window_reg = v;
      restart_series();
    endfunction

    function logic [PRICE_BITS-1:0] span(logic [PRICE_BITS-1:0] a, logic [PRICE_BITS-1:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function void take_bar(logic [PRICE_BITS-1:0] hi, logic [PRICE_BITS-1:0] lo,
                           logic [PRICE_BITS-1:0] cl, logic st);
      int                    n;
      logic [PRICE_BITS-1:0] tr;
      logic [PRICE_BITS-1:0] t2;
      logic [PRICE_BITS-1:0] t3;
      logic [63:0]           scaled;
      atr_result_t           res;
      n = (window_reg == 0) ? 1 : ((window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg));
      res = '0;
      if (st) restart_series();
      if (have_close) begin
        tr = span(hi, lo);
        t2 = span(hi, last_close);
        t3 = span(lo, last_close);
        if (t2 > tr) tr = t2;
        if (t3 > tr) tr = t3;
        // Once the window is full, the range that falls out leaves the sum.
        if (held >= n) range_total -= ranges[(slot + MAX_WINDOW - n) % MAX_WINDOW];
        else held++;
        ranges[slot] = tr;
        range_total += tr;
        slot = (slot + 1) % MAX_WINDOW;
        if (held >= n) begin
          scaled = 64'(range_total) << FRACTION_BITS;
          res.value = VALUE_W'(scaled / 64'(n));
          res.valid = 1'b1;
        end
      end
      last_close = cl;
      have_close = 1;
      expected_atr.push_back(res);
    endfunction

    function void match_result(logic [VALUE_W-1:0] value, logic valid);
      atr_result_t want;
      if (expected_atr.size() == 0) begin
        $error("unexpected result transfer: atr_value %0h atr_valid %0b", value, valid);
        errors++;
        return;
      end
      want = expected_atr.pop_front();
      if (value !== want.value) begin
        $error("atr_value: expected %0h, actual %0h", want.value, value);
        errors++;
      end
      if (valid !== want.valid) begin
        $error("atr_valid: expected %0b, actual %0b", want.valid, valid);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [WIN_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // high_price, low_price, close_price
  logic                  in_tuser;    // start_series
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // atr_value
  logic                  out_tuser;   // atr_valid

  atr_tracker board;
  bit         steady;

  average_true_range_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Mostly short gaps, a few long ones, none at all while the steady flag is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  task automatic send_bar(logic [PRICE_BITS-1:0] hi, logic [PRICE_BITS-1:0] lo,
                          logic [PRICE_BITS-1:0] cl, logic st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cl, lo, hi};
    in_tuser  <= st;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.take_bar(hi, lo, cl, st);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (board.expected_atr.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.set_window(v);
  endtask

  // Series of plausible bars (low <= close <= high around a drifting level),
  // with some fully random bars and stray series restarts mixed in.
  task automatic run_window(int count);
    int               remaining;
    int               len;
    int               n;
    int unsigned      spread;
    longint           level;
    longint           lo_l;
    longint           hi_l;
    logic [PRICE_BITS-1:0] hi;
    logic [PRICE_BITS-1:0] lo;
    logic [PRICE_BITS-1:0] cl;
    logic             st;
    n = (board.window_reg == 0) ? 1 :
        ((board.window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(board.window_reg));
    remaining = count;
    while (remaining > 0) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 2 * n + 8);
      spread = 32'd1 << $urandom_range(0, 31);
      case ($urandom_range(0, 3))
        0: level = $urandom_range(0, 255);
        1: level = 64'hFFFF_FFFF - $urandom_range(0, 255);
        default: level = $urandom;
      endcase
      for (int k = 0; k < len && remaining > 0; k++) begin
        if ($urandom_range(0, 99) < 10) begin
          hi = $urandom;
          lo = $urandom;
          cl = $urandom;
          st = ($urandom_range(0, 9) == 0);
        end else begin
          lo_l = level - longint'($urandom_range(0, spread));
          hi_l = level + longint'($urandom_range(0, spread));
          if (lo_l < 0) lo_l = 0;
          if (hi_l > 64'hFFFF_FFFF) hi_l = 64'hFFFF_FFFF;
          lo = lo_l[31:0];
          hi = hi_l[31:0];
          cl = lo + PRICE_BITS'({$urandom, $urandom} % (hi_l - lo_l + 1));
          st = (k == 0);
          level = cl;
        end
        send_bar(hi, lo, cl, st);
        remaining--;
      end
    end
  endtask

  initial begin
    steady <= 1'b0;
    forever begin
      repeat ($urandom_range(200, 2000)) @(posedge clk);
      steady <= ~steady;
    end
  end

  // Result side: random back-pressure, and a check of each result transfer.
  initial begin
    int hold;
    hold = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) board.match_result(out_tdata, out_tuser);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin
    logic [WIN_W-1:0] windows[9];
    int               counts[9];
    windows = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd127, 7'd65, 7'd14, 7'd3, WIN_W'($urandom_range(0, 127))};
    counts  = '{90, 90, 100, 180, 160, 90, 90, 90, 90};
    board = new();
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bars at the reset window: full-scale ranges, high below low,
    // a restart in mid-series.
    send_bar(32'h0, 32'h0, 32'h0, 1'b0);
    send_bar(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    for (int i = 0; i < 14; i++)
      send_bar(32'hFFFF_FFFF, 32'h0, (i % 2) ? 32'h0 : 32'hFFFF_FFFF, 1'b0);
    send_bar(32'd5, 32'd3, 32'd4, 1'b1);
    send_bar(32'd3, 32'd5, 32'd4, 1'b0);
    send_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      write_window(windows[p]);
      run_window(counts[p]);
      wait_idle();
    end

    if (board.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #30ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* average_true_range_unit.f */
hw/rtl/atr_pkg.sv
hw/rtl/atr_ctrl.sv
hw/rtl/atr_dp.sv
hw/rtl/average_true_range_unit.sv
hw/rtl/atr_checker.sv
sim/testbench.sv
